FILE: rtl/mfr_pkg.sv
// Package for the message frame receiver: phase and result-kind codes,
// frame constants, and the state and result structs shared by all modules.
// No dependencies.
`timescale 1ns / 1ps

package mfr_pkg;

  // Frame geometry
  localparam int MAX_SENTENCES  = 6;
  localparam int SENTENCE_BYTES = 32;

  // Field widths
  localparam int BYTE_CNT_W = 9;
  localparam int PAIR_W     = BYTE_CNT_W - 1;
  localparam int NIBBLE_W   = 4;
  localparam int TOTAL_W    = 3;
  localparam int SIDX_W     = 3;
  localparam int CPOS_W     = 5;

  // Sync and decode constants
  localparam logic [7:0] BYTE_RESTART = 8'hF0;
  localparam logic [7:0] BYTE_SYNC1   = 8'h01;
  localparam logic [7:0] BYTE_SYNC2   = 8'h03;
  localparam logic [7:0] BYTE_SYNC3   = 8'h05;
  localparam logic [7:0] NIBBLE_MASK  = 8'h0F;

  // Pair numbers of the header bytes
  localparam logic [PAIR_W-1:0] PAIR_COUNT    = PAIR_W'(0);
  localparam logic [PAIR_W-1:0] PAIR_INTERVAL = PAIR_W'(1);
  localparam logic [PAIR_W-1:0] PAIR_TEXT0    = PAIR_W'(2);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC1,
    PH_SYNC2,
    PH_SYNC3,
    PH_FRAME
  } phase_t;

  typedef enum logic [1:0] {
    KIND_COUNT,
    KIND_INTERVAL,
    KIND_TEXT,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    phase_t                phase;
    logic [BYTE_CNT_W-1:0] byte_count;
    logic [NIBBLE_W-1:0]   held_nibble;
    logic [TOTAL_W-1:0]    sentence_total;
  } rx_state_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        value;
    logic [SIDX_W-1:0] sentence_index;
    logic [CPOS_W-1:0] char_position;
    logic              frame_end;
  } result_t;

endpackage

FILE: rtl/message_frame_receiver.sv
// Top level of the message frame receiver: state register, decoder and
// output register on stream-style ports. Depends on mfr_pkg and mfr_decode.
`timescale 1ns / 1ps

// The receiver takes one serial byte per transfer and can accept a byte in
// every clock cycle; each byte is decoded combinationally and its result,
// if any, appears in the output register on the next cycle. The input is
// stalled only while a result waits in that register and the output side is
// not ready. A byte 0xF0 always restarts synchronization; 0x01, 0x03, 0x05
// then open a frame. Frame bytes pair up into decoded bytes: the message
// count (kind 0), the interval (kind 1), then 32 text bytes per message
// (kind 2) tagged with sentence index and position. A count above six gives
// a kind 3 error and ends the frame. tlast marks the last result of a frame.

module message_frame_receiver
  import mfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_value, [10:8] sentence_index,
                                  // [15:11] char_position
  output logic [1:0]  out_tuser,  // [1:0] out_kind
  output logic        out_tlast   // frame_end
);

  rx_state_t state_r;
  rx_state_t state_nxt;
  logic      res_valid;
  result_t   res;
  logic      out_valid_r;
  result_t   res_r;
  logic      in_xfer;

  // A byte is taken whenever the output register is free or draining.
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  mfr_decode u_decode (
    .state     (state_r),
    .rx_byte   (in_tdata),
    .state_nxt (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  // Receiver state advances on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, byte_count: '0, held_nibble: '0,
                   sentence_total: '0};
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.char_position, res_r.sentence_index, res_r.value};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.frame_end;

endmodule

FILE: rtl/mfr_decode.sv
// Combinational byte decoder of the message frame receiver: next state and
// the result, if any, for one received byte. Depends on mfr_pkg.
`timescale 1ns / 1ps

module mfr_decode
  import mfr_pkg::*;
(
  input  rx_state_t  state,
  input  logic [7:0] rx_byte,
  output rx_state_t  state_nxt,
  output logic       res_valid,
  output result_t    res
);

  // Next state and result for one byte
  always_comb begin
    logic [NIBBLE_W-1:0] low_nib;
    logic [7:0]          value;
    logic [PAIR_W-1:0]   pair;
    logic [PAIR_W-1:0]   text_idx;
    logic [PAIR_W-1:0]   last_pair;

    low_nib   = NIBBLE_W'(rx_byte & NIBBLE_MASK);
    value     = {state.held_nibble, low_nib};
    pair      = state.byte_count[BYTE_CNT_W-1:1];
    text_idx  = pair - PAIR_TEXT0;
    last_pair = PAIR_W'(PAIR_W'(state.sentence_total) * PAIR_W'(SENTENCE_BYTES))
                + PAIR_W'(1);

    state_nxt = state;
    res_valid = 1'b0;
    res       = '{kind: KIND_COUNT, value: value, sentence_index: '0,
                  char_position: '0, frame_end: 1'b0};

    if (rx_byte == BYTE_RESTART) begin
      // Restart byte resynchronizes from any phase, dropping a frame.
      state_nxt.phase = PH_SYNC1;
    end else begin
      unique case (state.phase)
        PH_SYNC1: begin
          state_nxt.phase = (rx_byte == BYTE_SYNC1) ? PH_SYNC2 : PH_IDLE;
        end
        PH_SYNC2: begin
          state_nxt.phase = (rx_byte == BYTE_SYNC2) ? PH_SYNC3 : PH_IDLE;
        end
        PH_SYNC3: begin
          if (rx_byte == BYTE_SYNC3) begin
            state_nxt.phase          = PH_FRAME;
            state_nxt.byte_count     = '0;
            state_nxt.held_nibble    = '0;
            state_nxt.sentence_total = '0;
          end else begin
            state_nxt.phase = PH_IDLE;
          end
        end
        PH_FRAME: begin
          state_nxt.byte_count = state.byte_count + BYTE_CNT_W'(1);
          if (!state.byte_count[0]) begin
            // First byte of a pair carries the high nibble.
            state_nxt.held_nibble = low_nib;
          end else begin
            res_valid = 1'b1;
            if (pair == PAIR_COUNT) begin
              if (value > 8'(MAX_SENTENCES)) begin
                // Count too large: report it and abort the frame.
                res.kind        = KIND_ERROR;
                res.frame_end   = 1'b1;
                state_nxt.phase = PH_IDLE;
              end else begin
                res.kind                 = KIND_COUNT;
                state_nxt.sentence_total = TOTAL_W'(value);
              end
            end else if (pair == PAIR_INTERVAL) begin
              res.kind = KIND_INTERVAL;
              if (state.sentence_total == '0) begin
                // No text follows, so the interval closes the frame.
                res.frame_end   = 1'b1;
                state_nxt.phase = PH_IDLE;
              end
            end else begin
              res.kind           = KIND_TEXT;
              res.sentence_index = SIDX_W'(text_idx / SENTENCE_BYTES);
              res.char_position  = CPOS_W'(text_idx % SENTENCE_BYTES);
              if (pair >= last_pair) begin
                res.frame_end   = 1'b1;
                state_nxt.phase = PH_IDLE;
              end
            end
          end
        end
        default: begin
          // Idle ignores everything but the restart byte.
          state_nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/sv/message_frame_receiver_tb.sv
// Self-checking testbench for the message frame receiver: directed and random
// serial byte traffic with randomized stalls, checked against a scoreboard.
// Depends on mfr_pkg and the message_frame_receiver top level.
`timescale 1ns / 1ps

module message_frame_receiver_tb;
  import mfr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 360;
  localparam int DRAIN_CYCLES = 10;

  // Frame decoder copy plus the queue of results it expects.
  class frame_result_board;
    rx_state_t rx;
    result_t   expected_results[$];
    int        errors;

    function new();
      rx = '0;
      rx.phase = PH_IDLE;
      errors = 0;
    endfunction

    // Decodes one received byte; returns 1 when it yields a result.
    function bit decode_byte(input logic [7:0] b, output result_t r);
      logic [7:0] value;
      int pair;
      int last_pair;
      int t;
      r = '0;
      if (b == BYTE_RESTART) begin
        rx.phase = PH_SYNC1;
        return 1'b0;
      end
      case (rx.phase)
        PH_SYNC1: begin
          rx.phase = (b == BYTE_SYNC1) ? PH_SYNC2 : PH_IDLE;
          return 1'b0;
        end
        PH_SYNC2: begin
          rx.phase = (b == BYTE_SYNC2) ? PH_SYNC3 : PH_IDLE;
          return 1'b0;
        end
        PH_SYNC3: begin
          if (b == BYTE_SYNC3) begin
            rx.phase = PH_FRAME;
            rx.byte_count = '0;
            rx.held_nibble = '0;
            rx.sentence_total = '0;
          end else begin
            rx.phase = PH_IDLE;
          end
          return 1'b0;
        end
        PH_FRAME: ;
        default: begin
          rx.phase = PH_IDLE;
          return 1'b0;
        end
      endcase

      // The first byte of a pair only holds its low nibble.
      if (!rx.byte_count[0]) begin
        rx.held_nibble = b[3:0];
        rx.byte_count = rx.byte_count + BYTE_CNT_W'(1);
        return 1'b0;
      end
      value = {rx.held_nibble, b[3:0]};
      pair = int'(rx.byte_count[BYTE_CNT_W-1:1]);
      rx.byte_count = rx.byte_count + BYTE_CNT_W'(1);

      if (pair == PAIR_COUNT) begin
        if (value > MAX_SENTENCES) begin
          r.kind = KIND_ERROR;
          r.value = value;
          r.frame_end = 1'b1;
          rx.phase = PH_IDLE;
        end else begin
          rx.sentence_total = value[TOTAL_W-1:0];
          r.kind = KIND_COUNT;
          r.value = value;
        end
        return 1'b1;
      end
      if (pair == PAIR_INTERVAL) begin
        r.kind = KIND_INTERVAL;
        r.value = value;
        if (rx.sentence_total == 0) begin
          r.frame_end = 1'b1;
          rx.phase = PH_IDLE;
        end
        return 1'b1;
      end

      // Text bytes: tagged with sentence and position, last one ends the frame.
      last_pair = int'(rx.sentence_total) * SENTENCE_BYTES + 1;
      t = pair - int'(PAIR_TEXT0);
      r.kind = KIND_TEXT;
      r.value = value;
      r.sentence_index = SIDX_W'(t / SENTENCE_BYTES);
      r.char_position = CPOS_W'(t % SENTENCE_BYTES);
      if (pair >= last_pair) begin
        r.frame_end = 1'b1;
        rx.phase = PH_IDLE;
      end
      return 1'b1;
    endfunction

    function void note_byte(input logic [7:0] b);
      result_t r;
      if (decode_byte(b, r)) expected_results.push_back(r);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(input result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing expected (kind %s, value %0d)",
                         got.kind.name(), got.value));
        return;
      end
      want = expected_results.pop_front();
      if (got.kind != want.kind)
        report($sformatf("kind %s, expected %s", got.kind.name(), want.kind.name()));
      if (got.value != want.value)
        report($sformatf("value %0d, expected %0d", got.value, want.value));
      if (got.sentence_index != want.sentence_index)
        report($sformatf("sentence index %0d, expected %0d",
                         got.sentence_index, want.sentence_index));
      if (got.char_position != want.char_position)
        report($sformatf("char position %0d, expected %0d",
                         got.char_position, want.char_position));
      if (got.frame_end != want.frame_end)
        report($sformatf("frame end %0b, expected %0b", got.frame_end, want.frame_end));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  frame_result_board board;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  int cycle_count = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;

  // Short checks of sync mismatches, count errors, restarts and a zero count.
  localparam logic [7:0] DIRECTED_BYTES [27] = '{
    BYTE_RESTART, 8'h02,
    BYTE_RESTART, BYTE_SYNC1, BYTE_SYNC1,
    BYTE_RESTART, BYTE_SYNC1, BYTE_SYNC2, BYTE_SYNC2,
    BYTE_RESTART, BYTE_SYNC1, BYTE_SYNC2, BYTE_SYNC3, 8'h30, 8'h07,
    BYTE_RESTART, BYTE_SYNC1, BYTE_SYNC2, BYTE_SYNC3, BYTE_RESTART,
    BYTE_SYNC1, BYTE_SYNC2, BYTE_SYNC3, 8'hE0, 8'h00, 8'h0F, 8'h8F
  };

  message_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  // Output side: random stalls, plus a long hold each time one is asked for.
  always @(posedge clk) begin
    if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every transfer on either side goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_byte(in_tdata);
      if (out_tvalid && out_tready)
        board.check_result(result_t'({kind_t'(out_tuser), out_tdata[7:0],
                                      out_tdata[10:8], out_tdata[15:11], out_tlast}));
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Frame byte carrying a nibble under a random upper nibble, never a restart.
  function automatic logic [7:0] frame_nibble(input logic [3:0] n);
    logic [7:0] x;
    x = {4'($urandom_range(15)), n};
    if (x == BYTE_RESTART) x[7] = 1'b0;
    return x;
  endfunction

  // Sync sequence and frame body; a cut ends the frame early with a restart.
  task automatic send_frame(input int count_value, input bit truncate);
    int total_bytes;
    int cut;
    logic [7:0] cur;
    total_bytes = (count_value > MAX_SENTENCES) ? 2 : 2 * (2 + count_value * SENTENCE_BYTES);
    cut = truncate ? $urandom_range(total_bytes - 1) : total_bytes;
    cur = '0;
    send_byte(BYTE_RESTART);
    send_byte(BYTE_SYNC1);
    send_byte(BYTE_SYNC2);
    send_byte(BYTE_SYNC3);
    for (int i = 0; i < total_bytes; i++) begin
      if (i == cut) begin
        send_byte(BYTE_RESTART);
        return;
      end
      if (i % 2 == 0) cur = (i == 0) ? 8'(count_value) : 8'($urandom);
      send_byte(frame_nibble((i % 2 == 0) ? cur[7:4] : cur[3:0]));
    end
  endtask

  // Mostly well-formed frames of small counts, with noise and broken syncs.
  task automatic random_traffic(input int stop_at);
    int pick;
    int count_value;
    int n;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(8'($urandom));
      end else if (pick < 18) begin
        send_byte(BYTE_RESTART);
        if ($urandom_range(1)) send_byte(BYTE_SYNC1);
        if ($urandom_range(1)) send_byte(BYTE_SYNC2);
        send_byte(8'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 10) count_value = $urandom_range(MAX_SENTENCES + 1, 255);
        else if (pick < 35) count_value = 0;
        else if (pick < 70) count_value = 1;
        else if (pick < 90) count_value = $urandom_range(2, 3);
        else count_value = $urandom_range(4, MAX_SENTENCES);
        send_frame(count_value, $urandom_range(99) < 12);
      end
    end
  endtask

  // Lets the last input transfer reach the scoreboard, then waits until nothing is pending.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);
    wait_drained();

    // Slow receiver; a long hold fills the block during a full-size frame.
    send_idle_pct = 34;
    recv_idle_pct = 84;
    hold_asked <= hold_asked + 1;
    send_frame(MAX_SENTENCES, 1'b0);
    random_traffic(bytes_sent + PHASE_BYTES);
    wait_drained();

    // Slow sender.
    send_idle_pct = 84;
    recv_idle_pct = 34;
    random_traffic(bytes_sent + PHASE_BYTES);
    wait_drained();

    // Both sides at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(bytes_sent + PHASE_BYTES);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
